/* design/fitc_pkg.sv */
// shared types and constants for the subtree mark counter
// no dependencies; imported by fenwick_interval_toggle_counter
package fitc_pkg;

    localparam int POS_W             = 11;     // width of tour positions and of the size register
    localparam int SUM_W             = 11;     // tree sums kept modulo 2048
    localparam int COUNT_W           = 10;     // subtree count width
    localparam int DEFAULT_POSITIONS = 1024;

    localparam logic [POS_W-1:0] CFG_RESET = 11'd1024;
    localparam logic [SUM_W-1:0] SUM_MINUS_ONE = '1;
    localparam logic [SUM_W-1:0] SUM_PLUS_ONE  = 11'd1;

    // item kinds
    localparam logic KIND_TOGGLE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef enum logic [4:0] {
        ST_INIT = 5'b00001,
        ST_IDLE = 5'b00010,
        ST_MARK = 5'b00100,
        ST_ADD  = 5'b01000,
        ST_SUM  = 5'b10000
    } state_t;

endpackage

/* design/fenwick_interval_toggle_counter.sv */
// subtree mark counter: binary indexed tree over euler tour positions
// depends on fitc_pkg (widths, kind codes, sequencer states)

// Usage: after reset the block runs an initialization pass over every store
// address (busy high) that loads every tree entry with the lowest set bit of
// its one-based index and sets every node mark. Configuration writes are taken
// during that pass and whenever the block is idle with no start pending;
// cfg_ready is low while a walk is in flight, so the effective size never
// changes under an item. An item is taken when start is high and busy is low.
// A toggle walks the tree upward from the entry position and then from the
// exit position, one tree entry per cycle through a single read-modify-write
// sum port: the accept cycle, then a mark step, then up to log2(M) + 1 entries
// per walk. A toggle with a position of zero or above the effective size is
// dropped in the accept cycle. A query walks two prefix sums downward, one
// entry per cycle; an empty range answers in the cycle after accept. Each
// query word appears on subtree_count for exactly one cycle with count_valid
// high; there is no back-pressure, so the receiver must take it in that cycle.
module fenwick_interval_toggle_counter
    import fitc_pkg::*;
#(
    parameter int POSITIONS = DEFAULT_POSITIONS
) (
    input  logic               clk,
    input  logic               rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  logic               kind,
    input  logic [POS_W-1:0]   entry_pos,
    input  logic [POS_W-1:0]   exit_pos,
    // result strobe
    output logic               count_valid,
    output logic [COUNT_W-1:0] subtree_count,
    // size register write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [POS_W-1:0]   cfg_data
);

    // address width of the stores, and walk index width with headroom
    // for index + lowbit(index) and for 11-bit inputs
    localparam int AW  = $clog2(POSITIONS);
    localparam int IXW = ($clog2(POSITIONS + 1) > POS_W) ? $clog2(POSITIONS + 1) : POS_W;
    localparam int CW  = IXW + 1;

    localparam logic [CW-1:0] POS_MAX  = CW'(POSITIONS);
    localparam logic [AW-1:0] LAST_ADR = AW'(POSITIONS - 1);

    // control state
    state_t             state_reg, state_next;
    logic [AW-1:0]      init_adr_reg, init_adr_next;
    logic [POS_W-1:0]   cfg_reg, cfg_next;
    logic               count_valid_reg, count_valid_next;

    // walk state
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      exit_reg, exit_next;
    logic [SUM_W-1:0]   delta_reg, delta_next;
    logic [SUM_W-1:0]   acc_reg, acc_next;
    logic               phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // tree sum store: one write and one registered read per cycle
    logic [SUM_W-1:0]   sums_mem [POSITIONS];
    logic               sums_we, sums_re;
    logic [AW-1:0]      sums_waddr, sums_raddr;
    logic [SUM_W-1:0]   sums_wdata, sums_rd_reg;

    // node mark store, indexed by entry position
    logic               marks_mem [POSITIONS];
    logic               marks_we, marks_re;
    logic [AW-1:0]      marks_waddr, marks_raddr;
    logic               marks_wdata, marks_rd_reg;

    // datapath helpers
    logic [CW-1:0]      m_eff;
    logic [CW-1:0]      entry_w, exit_w, lo_raw, lo_sat, hi_sat;
    logic [CW-1:0]      idx_low, step_up, step_down;
    logic [CW-1:0]      init_pos, init_low;
    logic [SUM_W-1:0]   acc_sum;

    // effective size is the smaller of the register and the store depth
    assign m_eff   = (CW'(cfg_reg) < POS_MAX) ? CW'(cfg_reg) : POS_MAX;
    assign entry_w = CW'(entry_pos);
    assign exit_w  = CW'(exit_pos);

    // query bounds, saturated into 0..m
    assign lo_raw = (entry_w == '0) ? '0 : entry_w - CW'(1);
    assign lo_sat = (lo_raw > m_eff) ? m_eff : lo_raw;
    assign hi_sat = (exit_w > m_eff) ? m_eff : exit_w;

    // fenwick index steps
    assign idx_low   = idx_reg & (~idx_reg + CW'(1));
    assign step_up   = idx_reg + idx_low;
    assign step_down = idx_reg - idx_low;

    // init pass loads lowbit(address + 1)
    assign init_pos = CW'(init_adr_reg) + CW'(1);
    assign init_low = init_pos & (~init_pos + CW'(1));

    // prefix walk adds on the upper bound, subtracts on the lower one
    assign acc_sum = phase_reg ? (acc_reg - sums_rd_reg) : (acc_reg + sums_rd_reg);

    always_comb
    begin
        state_next       = state_reg;
        init_adr_next    = init_adr_reg;
        cfg_next         = cfg_reg;
        count_valid_next = 1'b0;
        idx_next         = idx_reg;
        lo_next          = lo_reg;
        exit_next        = exit_reg;
        delta_next       = delta_reg;
        acc_next         = acc_reg;
        phase_next       = phase_reg;
        count_next       = count_reg;

        sums_we     = 1'b0;
        sums_waddr  = '0;
        sums_wdata  = '0;
        sums_re     = 1'b0;
        sums_raddr  = '0;
        marks_we    = 1'b0;
        marks_waddr = '0;
        marks_wdata = 1'b0;
        marks_re    = 1'b0;
        marks_raddr = '0;

        if (cfg_valid && cfg_ready)
        begin
            cfg_next = cfg_data;
        end

        case (state_reg)
            ST_INIT:
            begin
                sums_we     = 1'b1;
                sums_waddr  = init_adr_reg;
                sums_wdata  = init_low[SUM_W-1:0];
                marks_we    = 1'b1;
                marks_waddr = init_adr_reg;
                marks_wdata = 1'b1;
                init_adr_next = init_adr_reg + AW'(1);
                if (init_adr_reg == LAST_ADR)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == KIND_TOGGLE)
                    begin
                        // out of range toggles are dropped here
                        if (entry_w != '0 && entry_w <= m_eff &&
                            exit_w != '0 && exit_w <= m_eff)
                        begin
                            marks_re    = 1'b1;
                            marks_raddr = AW'(entry_w - CW'(1));
                            sums_re     = 1'b1;
                            sums_raddr  = AW'(entry_w - CW'(1));
                            idx_next    = entry_w;
                            exit_next   = exit_w;
                            phase_next  = 1'b0;
                            state_next  = ST_MARK;
                        end
                    end
                    else
                    begin
                        if (hi_sat <= lo_sat)
                        begin
                            count_next       = '0;
                            count_valid_next = 1'b1;
                        end
                        else
                        begin
                            sums_re    = 1'b1;
                            sums_raddr = AW'(hi_sat - CW'(1));
                            idx_next   = hi_sat;
                            lo_next    = lo_sat;
                            acc_next   = '0;
                            phase_next = 1'b0;
                            state_next = ST_SUM;
                        end
                    end
                end
            end

            ST_MARK:
            begin
                // set mark removes one, clear mark adds one
                delta_next  = marks_rd_reg ? SUM_MINUS_ONE : SUM_PLUS_ONE;
                marks_we    = 1'b1;
                marks_waddr = AW'(idx_reg - CW'(1));
                marks_wdata = ~marks_rd_reg;
                state_next  = ST_ADD;
            end

            ST_ADD:
            begin
                sums_we    = 1'b1;
                sums_waddr = AW'(idx_reg - CW'(1));
                sums_wdata = sums_rd_reg + delta_reg;
                if (step_up <= m_eff)
                begin
                    sums_re    = 1'b1;
                    sums_raddr = AW'(step_up - CW'(1));
                    idx_next   = step_up;
                end
                else if (!phase_reg)
                begin
                    // second walk from the exit position
                    sums_re    = 1'b1;
                    sums_raddr = AW'(exit_reg - CW'(1));
                    idx_next   = exit_reg;
                    phase_next = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SUM:
            begin
                acc_next = acc_sum;
                if (step_down != '0)
                begin
                    sums_re    = 1'b1;
                    sums_raddr = AW'(step_down - CW'(1));
                    idx_next   = step_down;
                end
                else if (!phase_reg && lo_reg != '0)
                begin
                    sums_re    = 1'b1;
                    sums_raddr = AW'(lo_reg - CW'(1));
                    idx_next   = lo_reg;
                    phase_next = 1'b1;
                end
                else
                begin
                    count_next       = acc_sum[SUM_W-1:1];
                    count_valid_next = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            init_adr_reg    <= '0;
            cfg_reg         <= CFG_RESET;
            count_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            init_adr_reg    <= init_adr_next;
            cfg_reg         <= cfg_next;
            count_valid_reg <= count_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        lo_reg    <= lo_next;
        exit_reg  <= exit_next;
        delta_reg <= delta_next;
        acc_reg   <= acc_next;
        phase_reg <= phase_next;
        count_reg <= count_next;
    end

    // sum store, write data forwarded on a same-address read
    always_ff @(posedge clk)
    begin
        if (sums_we)
        begin
            sums_mem[sums_waddr] <= sums_wdata;
        end
        if (sums_re)
        begin
            if (sums_we && sums_waddr == sums_raddr)
            begin
                sums_rd_reg <= sums_wdata;
            end
            else
            begin
                sums_rd_reg <= sums_mem[sums_raddr];
            end
        end
    end

    // mark store
    always_ff @(posedge clk)
    begin
        if (marks_we)
        begin
            marks_mem[marks_waddr] <= marks_wdata;
        end
        if (marks_re)
        begin
            marks_rd_reg <= marks_mem[marks_raddr];
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    // size writes only with no item in flight and none being taken
    assign cfg_ready     = (state_reg == ST_INIT) || (state_reg == ST_IDLE && !start);
    assign count_valid   = count_valid_reg;
    assign subtree_count = count_reg;

endmodule
